FILE: rtl/etnavg_pkg.sv
// Shared types and constants for the element-to-node area averaging block.
// Used by the front end, the queue and the back end; depends on nothing.
`default_nettype none

package etnavg_pkg;

  localparam int VTX_W    = 11;
  localparam int VAL_W    = 32;
  localparam int PROD_W   = 64;
  localparam int ASUM_W   = 48;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;
  localparam int QCNT_W   = 3;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic {
    OP_ADD,
    OP_READ
  } op_kind_t;

  // One vertex operation as it travels from the front end to the back end.
  typedef struct packed {
    op_kind_t                   kind;
    logic                       in_range;
    logic [VTX_W-1:0]           vnum;
    logic signed [PROD_W-1:0]   prod;
    logic [VAL_W-1:0]           area;
  } qent_t;

  typedef struct packed {
    logic  vld;
    qent_t ent;
  } q_wr_t;

  // Per-vertex record held in the node store.
  typedef struct packed {
    logic signed [PROD_W-1:0] vsum;
    logic [ASUM_W-1:0]        asum;
    logic                     mark;
  } node_rec_t;

endpackage

`default_nettype wire

FILE: rtl/etnavg_front.sv
// Front end: accepts requests, forms the triangle product and splits each
// triangle into per-corner operations. Depends on etnavg_pkg.
`default_nettype none

module etnavg_front #(
  parameter int VERTICES = 1024
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  clr_busy,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  in_func,
  input  wire [etnavg_pkg::VTX_W-1:0]          in_vertex_a,
  input  wire [etnavg_pkg::VTX_W-1:0]          in_vertex_b,
  input  wire [etnavg_pkg::VTX_W-1:0]          in_vertex_c,
  input  wire signed [etnavg_pkg::VAL_W-1:0]   in_element_value,
  input  wire [etnavg_pkg::VAL_W-1:0]          in_element_area,
  input  wire [etnavg_pkg::VTX_W-1:0]          in_read_vertex,
  input  wire                                  q_full,
  output etnavg_pkg::q_wr_t                    q_wr
);
  import etnavg_pkg::*;

  localparam logic [16:0] VMAX = 17'(VERTICES);

  typedef enum logic [2:0] {
    F_IDLE,
    F_C0,
    F_C1,
    F_C2,
    F_RD
  } fstate_t;

  fstate_t                  state_r;
  logic [VTX_W-1:0]         va_r, vb_r, vc_r, rv_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [VAL_W-1:0]         area_r;

  logic signed [64:0]       prod_full;
  logic [VTX_W-1:0]         corner;
  logic                     corner_ok;
  logic                     rd_ok;
  logic                     step_done;
  logic                     take;

  function automatic logic vtx_ok(input logic [VTX_W-1:0] v);
    return (v != '0) && (17'(v) <= VMAX);
  endfunction

  assign prod_full = $signed({{33{in_element_value[VAL_W-1]}}, in_element_value})
                   * $signed({33'b0, in_element_area});

  always_comb begin
    unique case (state_r)
      F_C0:    corner = va_r;
      F_C1:    corner = vb_r;
      F_C2:    corner = vc_r;
      default: corner = rv_r;
    endcase
  end

  assign corner_ok = vtx_ok(corner);
  assign rd_ok     = vtx_ok(rv_r);

  // A corner outside the mesh is dropped without a queue write; its state is still visited.
  always_comb begin
    q_wr.vld          = 1'b0;
    q_wr.ent.kind     = OP_ADD;
    q_wr.ent.in_range = corner_ok;
    q_wr.ent.vnum     = corner;
    q_wr.ent.prod     = prod_r;
    q_wr.ent.area     = area_r;
    step_done         = 1'b0;
    unique case (state_r)
      F_C0, F_C1, F_C2: begin
        q_wr.vld  = corner_ok && !q_full;
        step_done = !corner_ok || !q_full;
      end
      F_RD: begin
        q_wr.vld          = !q_full;
        q_wr.ent.kind     = OP_READ;
        q_wr.ent.in_range = rd_ok;
        step_done         = !q_full;
      end
      default: begin
        step_done = 1'b0;
      end
    endcase
  end

  assign in_ready = !clr_busy &&
                    ((state_r == F_IDLE) ||
                     (((state_r == F_C2) || (state_r == F_RD)) && step_done));
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      if (take) begin
        state_r <= (in_func == FUNC_READ) ? F_RD : F_C0;
      end else begin
        unique case (state_r)
          F_C0:    if (step_done) state_r <= F_C1;
          F_C1:    if (step_done) state_r <= F_C2;
          F_C2:    if (step_done) state_r <= F_IDLE;
          F_RD:    if (step_done) state_r <= F_IDLE;
          default: state_r <= F_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      va_r   <= in_vertex_a;
      vb_r   <= in_vertex_b;
      vc_r   <= in_vertex_c;
      rv_r   <= in_read_vertex;
      prod_r <= prod_full[PROD_W-1:0];
      area_r <= in_element_area;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/etnavg_queue.sv
// Short operation queue between the front and back ends.
// Depends on etnavg_pkg for the entry type and depth.
`default_nettype none

module etnavg_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  etnavg_pkg::q_wr_t  q_wr,
  output logic               q_full,
  input  wire                q_pop,
  output logic               q_nempty,
  output etnavg_pkg::qent_t  q_head
);
  import etnavg_pkg::*;

  qent_t              store_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_push, do_pop;

  assign q_full   = (cnt_r == QCNT_W'(QDEPTH));
  assign q_nempty = (cnt_r != '0);
  assign q_head   = store_r[rd_ptr_r];
  assign do_push  = q_wr.vld && !q_full;
  assign do_pop   = q_pop && q_nempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= q_wr.ent;
  end

endmodule

`default_nettype wire

FILE: rtl/etnavg_back.sv
// Back end: node store with read-modify-write update, clearing pass after
// reset, serial divider for reads and the output register. Uses etnavg_pkg.
`default_nettype none

module etnavg_back #(
  parameter int VERTICES = 1024
) (
  input  wire                                clk,
  input  wire                                rst_n,
  output logic                               clr_busy,
  input  wire                                q_nempty,
  input  etnavg_pkg::qent_t                  q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [etnavg_pkg::VAL_W-1:0] out_node_value,
  output logic                               out_no_weight,
  output logic                               out_saturated
);
  import etnavg_pkg::*;

  localparam int            IW       = $clog2(VERTICES);
  localparam logic [IW-1:0] LAST_IDX = IW'(VERTICES - 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } dstate_t;

  // Node store.
  node_rec_t  mem [VERTICES];
  node_rec_t  mem_rdata_r;
  logic       mem_we;
  logic [IW-1:0] mem_waddr;
  node_rec_t  mem_wdata;

  // Clearing pass.
  logic          clr_busy_r;
  logic [IW-1:0] clr_idx_r;

  // Update stage and write forwarding.
  logic          s1_vld_r;
  qent_t         s1_op_r;
  logic [IW-1:0] s1_idx_r;
  logic          fwd_vld_r;
  logic [IW-1:0] fwd_idx_r;
  node_rec_t     fwd_rec_r;

  node_rec_t     cur;
  node_rec_t     upd_rec;
  logic          s1_go;
  logic          s1_wr;
  logic [16:0]   idx_full;
  logic signed [PROD_W:0] vsum_ext;
  logic          v_ovf;
  logic [ASUM_W:0] asum_ext;
  logic          a_ovf;

  // Divider.
  dstate_t          dst_r;
  logic [ASUM_W-1:0] rem_r;
  logic [ASUM_W-1:0] div_a_r;
  logic [31:0]       lo_r;
  logic [31:0]       quo_r;
  logic [4:0]        cnt_r;
  logic              neg_r;
  logic              big_r;
  logic              nw_r;
  logic              msat_r;
  logic              out_vld_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic              out_nw_r;
  logic              out_sat_r;

  logic [PROD_W-1:0] mag;
  logic              start_neg;
  logic [ASUM_W:0]   rem_sh;
  logic [ASUM_W:0]   rem_dif;
  logic              ge;
  logic              sat_q;
  logic [31:0]       res_val;
  logic              start_rd;
  logic              out_free;

  assign clr_busy = clr_busy_r;

  assign cur = (fwd_vld_r && (fwd_idx_r == s1_idx_r)) ? fwd_rec_r : mem_rdata_r;

  // Saturating accumulation for one corner.
  assign vsum_ext = {cur.vsum[PROD_W-1], cur.vsum} + {s1_op_r.prod[PROD_W-1], s1_op_r.prod};
  assign v_ovf    = vsum_ext[PROD_W] ^ vsum_ext[PROD_W-1];
  assign asum_ext = {1'b0, cur.asum} + (ASUM_W+1)'(s1_op_r.area);
  assign a_ovf    = asum_ext[ASUM_W];

  always_comb begin
    if (s1_op_r.kind == OP_ADD) begin
      if (v_ovf) begin
        upd_rec.vsum = vsum_ext[PROD_W] ? {1'b1, {(PROD_W-1){1'b0}}}
                                        : {1'b0, {(PROD_W-1){1'b1}}};
      end else begin
        upd_rec.vsum = vsum_ext[PROD_W-1:0];
      end
      upd_rec.asum = a_ovf ? {ASUM_W{1'b1}} : asum_ext[ASUM_W-1:0];
      upd_rec.mark = cur.mark | v_ovf | a_ovf;
    end else begin
      upd_rec = '0;
    end
  end

  // A read waits in the update stage until the divider is free.
  assign s1_go    = s1_vld_r && ((s1_op_r.kind == OP_ADD) || (dst_r == D_IDLE));
  assign s1_wr    = s1_go && s1_op_r.in_range;
  assign start_rd = s1_go && (s1_op_r.kind == OP_READ);
  assign q_pop    = q_nempty && !clr_busy_r && (!s1_vld_r || s1_go);
  assign idx_full = 17'(q_head.vnum) - 17'd1;

  assign mem_we    = clr_busy_r || s1_wr;
  assign mem_waddr = clr_busy_r ? clr_idx_r : s1_idx_r;
  assign mem_wdata = clr_busy_r ? node_rec_t'('0) : upd_rec;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (q_pop)  mem_rdata_r   <= mem[idx_full[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      s1_vld_r   <= 1'b0;
      fwd_vld_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) clr_busy_r <= 1'b0;
      end
      if (q_pop) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_wr) fwd_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_op_r  <= q_head;
      s1_idx_r <= idx_full[IW-1:0];
    end
    if (s1_wr) begin
      fwd_idx_r <= s1_idx_r;
      fwd_rec_r <= upd_rec;
    end
  end

  // Divider datapath: restoring division, one quotient bit per cycle.
  assign start_neg = cur.vsum[PROD_W-1];
  assign mag       = start_neg ? (PROD_W'(0) - PROD_W'(cur.vsum)) : PROD_W'(cur.vsum);
  assign rem_sh    = {rem_r, lo_r[31]};
  assign rem_dif   = rem_sh - {1'b0, div_a_r};
  assign ge        = (rem_sh >= {1'b0, div_a_r});

  assign sat_q   = big_r || (neg_r ? (quo_r > 32'h8000_0000) : quo_r[31]);
  assign res_val = sat_q ? (neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF)
                         : (neg_r ? (32'd0 - quo_r) : quo_r);
  assign out_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_r     <= D_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_ready && (dst_r != D_DONE)) out_vld_r <= 1'b0;
      unique case (dst_r)
        D_IDLE: begin
          if (start_rd) begin
            quo_r   <= '0;
            cnt_r   <= '0;
            div_a_r <= cur.asum;
            if (!s1_op_r.in_range) begin
              nw_r   <= 1'b1;
              msat_r <= 1'b0;
              neg_r  <= 1'b0;
              big_r  <= 1'b0;
              dst_r  <= D_DONE;
            end else if (cur.asum == '0) begin
              nw_r   <= 1'b1;
              msat_r <= cur.mark;
              neg_r  <= 1'b0;
              big_r  <= 1'b0;
              dst_r  <= D_DONE;
            end else begin
              nw_r   <= 1'b0;
              msat_r <= cur.mark;
              neg_r  <= start_neg;
              rem_r  <= ASUM_W'(mag[63:32]);
              lo_r   <= mag[31:0];
              // A quotient of 2^32 or more clamps without dividing.
              if (ASUM_W'(mag[63:32]) >= cur.asum) begin
                big_r <= 1'b1;
                dst_r <= D_DONE;
              end else begin
                big_r <= 1'b0;
                dst_r <= D_RUN;
              end
            end
          end
        end
        D_RUN: begin
          rem_r <= ge ? rem_dif[ASUM_W-1:0] : rem_sh[ASUM_W-1:0];
          quo_r <= {quo_r[30:0], ge};
          lo_r  <= {lo_r[30:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd31) dst_r <= D_DONE;
        end
        D_DONE: begin
          if (out_free) begin
            out_vld_r <= 1'b1;
            out_val_r <= nw_r ? '0 : $signed(res_val);
            out_nw_r  <= nw_r;
            out_sat_r <= msat_r | (!nw_r && sat_q);
            dst_r     <= D_IDLE;
          end
        end
        default: dst_r <= D_IDLE;
      endcase
    end
  end

  assign out_valid      = out_vld_r;
  assign out_node_value = out_val_r;
  assign out_no_weight  = out_nw_r;
  assign out_saturated  = out_sat_r;

endmodule

`default_nettype wire

FILE: rtl/element_to_node_area_average_unit.sv
// Top level of the element-to-node area averaging block.
// Instantiates etnavg_front, etnavg_queue and etnavg_back; uses etnavg_pkg.
//
// Usage: the input channel (in_valid/in_ready) carries one request per
// transfer. in_func selects an add (one triangle: three one-based corner
// numbers, a signed Q16.16 value and an unsigned Q16.16 area) or a read of
// one vertex. An add produces no result; a read produces one result on the
// output channel (out_valid/out_ready): the area-weighted average in signed
// Q16.16, a no-weight flag and a saturation flag. The read clears the vertex.
// Flow: an add becomes one operation per corner, and the node store
// handles one read-modify-write per cycle unless a read waits for the
// divider. A read passes through the store update and then the
// one-bit-per-cycle divider, whose result goes to the output register.
// A four-entry queue separates request intake from the store so the
// front end keeps taking adds while a division runs, until it fills.
// Reset: after rst_n is released the store is cleared one entry per cycle,
// with in_ready held low. A stalled receiver holds the result in the
// output register; further reads then back up into the queue and finally
// stop intake.
`default_nettype none

module element_to_node_area_average_unit #(
  parameter int VERTICES = 1024
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_func,
  input  wire [etnavg_pkg::VTX_W-1:0]        in_vertex_a,
  input  wire [etnavg_pkg::VTX_W-1:0]        in_vertex_b,
  input  wire [etnavg_pkg::VTX_W-1:0]        in_vertex_c,
  input  wire signed [etnavg_pkg::VAL_W-1:0] in_element_value,
  input  wire [etnavg_pkg::VAL_W-1:0]        in_element_area,
  input  wire [etnavg_pkg::VTX_W-1:0]        in_read_vertex,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [etnavg_pkg::VAL_W-1:0] out_node_value,
  output logic                               out_no_weight,
  output logic                               out_saturated
);
  import etnavg_pkg::*;

  q_wr_t  q_wr;
  logic   q_full;
  logic   q_pop;
  logic   q_nempty;
  qent_t  q_head;
  logic   clr_busy;

  etnavg_front #(.VERTICES(VERTICES)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .clr_busy         (clr_busy),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .in_vertex_c      (in_vertex_c),
    .in_element_value (in_element_value),
    .in_element_area  (in_element_area),
    .in_read_vertex   (in_read_vertex),
    .q_full           (q_full),
    .q_wr             (q_wr)
  );

  etnavg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_wr     (q_wr),
    .q_full   (q_full),
    .q_pop    (q_pop),
    .q_nempty (q_nempty),
    .q_head   (q_head)
  );

  etnavg_back #(.VERTICES(VERTICES)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .clr_busy       (clr_busy),
    .q_nempty       (q_nempty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_node_value (out_node_value),
    .out_no_weight  (out_no_weight),
    .out_saturated  (out_saturated)
  );

endmodule

`default_nettype wire

FILE: rtl/etnavg_checker.sv
// Port-level checks for the element-to-node area averaging block, attached
// to the top level by the bind statement at the end. Depends on etnavg_pkg.
`default_nettype none

module etnavg_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_ready,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire signed [etnavg_pkg::VAL_W-1:0] out_node_value,
  input wire                                out_no_weight,
  input wire                                out_saturated
);
  import etnavg_pkg::*;

  // A result waiting on the receiver keeps all of its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_node_value) &&
                                $stable(out_no_weight) && $stable(out_saturated))
    else $error("result changed while stalled");

  // A vertex without weight always reports a zero average.
  a_nw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_weight |-> out_node_value == '0)
    else $error("no-weight result with nonzero value");

  // Nothing is shown right after reset.
  a_rst_out: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result visible right after reset");

  // The store is being cleared right after reset, so intake is closed.
  a_rst_in: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !in_ready)
    else $error("request taken during clearing pass");

endmodule

bind element_to_node_area_average_unit etnavg_checker u_etnavg_checker (.*);

`default_nettype wire

FILE: tb/tb_element_to_node_area_average_unit.sv
// Self-checking bench for element_to_node_area_average_unit: random triangle adds and
// vertex reads, checked against a vertex-sum scoreboard kept in the bench.
// Depends on etnavg_pkg and the RTL of the block; needs no files or arguments.

module tb_element_to_node_area_average_unit;
  import etnavg_pkg::*;

  localparam int VTX_COUNT  = 1024;
  localparam int STALL_LIMIT = 6000;
  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_TAIL = 50;
  localparam longint VSUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint VSUM_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [ASUM_W-1:0] AREA_MAX = '1;

  typedef struct {
    logic                    func;
    logic [VTX_W-1:0]        va;
    logic [VTX_W-1:0]        vb;
    logic [VTX_W-1:0]        vc;
    logic signed [VAL_W-1:0] value;
    logic [VAL_W-1:0]        area;
    logic [VTX_W-1:0]        rvert;
  } vertex_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    no_weight;
    logic                    saturated;
  } node_avg_t;

  typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  // Mirror of the per-vertex sums and the queue of averages still owed.
  class vertex_average_board;
    longint            vsum [VTX_COUNT];
    logic [ASUM_W-1:0] asum [VTX_COUNT];
    bit                mark [VTX_COUNT];
    node_avg_t         pending_averages[$];
    int mismatches, adds_seen, reads_seen, results_checked, sat_results, empty_results;

    function new();
      foreach (vsum[i]) begin
        vsum[i] = 0;
        asum[i] = '0;
        mark[i] = 1'b0;
      end
    endfunction

    function void add_corner(logic [VTX_W-1:0] vnum, longint prod, logic [VAL_W-1:0] area);
      int unsigned idx;
      longint total;
      logic [ASUM_W:0] atot;
      if (vnum == 0 || vnum > VTX_COUNT) return;
      idx = vnum - 1;
      total = vsum[idx] + prod;
      if (prod > 0 && vsum[idx] > 0 && total < 0) begin
        total = VSUM_MAX;
        mark[idx] = 1'b1;
      end else if (prod < 0 && vsum[idx] < 0 && total >= 0) begin
        total = VSUM_MIN;
        mark[idx] = 1'b1;
      end
      vsum[idx] = total;
      atot = asum[idx] + area;
      if (atot[ASUM_W]) begin
        asum[idx] = AREA_MAX;
        mark[idx] = 1'b1;
      end else begin
        asum[idx] = atot[ASUM_W-1:0];
      end
    endfunction

    function void note_request(vertex_req_t r);
      longint prod;
      int unsigned idx;
      longint s;
      logic [ASUM_W-1:0] a;
      logic [63:0] mag, quo;
      node_avg_t res;
      if (r.func == FUNC_ADD) begin
        adds_seen++;
        prod = longint'(r.value) * longint'(r.area);
        add_corner(r.va, prod, r.area);
        add_corner(r.vb, prod, r.area);
        add_corner(r.vc, prod, r.area);
        return;
      end
      reads_seen++;
      res.value = '0;
      res.no_weight = 1'b1;
      res.saturated = 1'b0;
      if (r.rvert != 0 && r.rvert <= VTX_COUNT) begin
        idx = r.rvert - 1;
        s = vsum[idx];
        a = asum[idx];
        res.saturated = mark[idx];
        vsum[idx] = 0;
        asum[idx] = '0;
        mark[idx] = 1'b0;
        if (a != 0) begin
          res.no_weight = 1'b0;
          mag = s;
          if (s < 0) mag = -mag;
          quo = mag / {16'd0, a};
          // The quotient truncates toward zero and clamps to the 32-bit range.
          if (s < 0) begin
            if (quo > 64'h8000_0000) begin
              quo = 64'h8000_0000;
              res.saturated = 1'b1;
            end
            res.value = -quo[31:0];
          end else begin
            if (quo > 64'h7FFF_FFFF) begin
              quo = 64'h7FFF_FFFF;
              res.saturated = 1'b1;
            end
            res.value = quo[31:0];
          end
        end
      end
      pending_averages.push_back(res);
    endfunction

    function void check_average(logic signed [VAL_W-1:0] value, logic no_weight,
                                logic saturated);
      node_avg_t want;
      if (pending_averages.size() == 0) begin
        $error("node result with no read request waiting: node_value %0d", value);
        mismatches++;
        return;
      end
      want = pending_averages.pop_front();
      results_checked++;
      if (want.saturated) sat_results++;
      if (want.no_weight) empty_results++;
      if (value !== want.value) begin
        $error("node_value: expected %0d, actual %0d", want.value, value);
        mismatches++;
      end
      if (no_weight !== want.no_weight) begin
        $error("no_weight: expected %0b, actual %0b", want.no_weight, no_weight);
        mismatches++;
      end
      if (saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, saturated);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [VTX_W-1:0] in_vertex_a = '0;
  logic [VTX_W-1:0] in_vertex_b = '0;
  logic [VTX_W-1:0] in_vertex_c = '0;
  logic signed [VAL_W-1:0] in_element_value = '0;
  logic [VAL_W-1:0] in_element_area = '0;
  logic [VTX_W-1:0] in_read_vertex = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_node_value;
  logic out_no_weight;
  logic out_saturated;

  vertex_average_board board;
  int idle_cycles = 0;
  int stall_orders = 0;
  int stall_served = 0;
  int hold_left = 0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  logic [VTX_W-1:0] vertex_pool [4];
  int pool_size = 1;

  element_to_node_area_average_unit #(.VERTICES(VTX_COUNT)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .in_vertex_c      (in_vertex_c),
    .in_element_value (in_element_value),
    .in_element_area  (in_element_area),
    .in_read_vertex   (in_read_vertex),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_node_value   (out_node_value),
    .out_no_weight    (out_no_weight),
    .out_saturated    (out_saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    vertex_req_t seen;
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_average(out_node_value, out_no_weight, out_saturated);
      if (in_valid && in_ready) begin
        seen.func  = in_func;
        seen.va    = in_vertex_a;
        seen.vb    = in_vertex_b;
        seen.vc    = in_vertex_c;
        seen.value = in_element_value;
        seen.area  = in_element_area;
        seen.rvert = in_read_vertex;
        board.note_request(seen);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random ready patterns, plus a long hold-off whenever one is ordered.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_orders != stall_served) begin
      stall_served <= stall_orders;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 160);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh8000_0000;
      3:       return '0;
      default: return int'($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] random_area();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      2:       return '0;
      3:       return $urandom_range(1, 16);
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  function automatic vertex_req_t random_request();
    vertex_req_t r;
    r.func  = 1'($urandom_range(0, 1));
    r.va    = VTX_W'($urandom_range(0, 2047));
    r.vb    = VTX_W'($urandom_range(0, 2047));
    r.vc    = VTX_W'($urandom_range(0, 2047));
    r.value = $urandom;
    r.area  = $urandom;
    r.rvert = VTX_W'($urandom_range(0, 2047));
    return r;
  endfunction

  // Mostly a corner from the current pool, now and then one that the block skips.
  function automatic logic [VTX_W-1:0] pick_corner();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return VTX_W'($urandom_range(VTX_COUNT + 1, 2047));
      default: return vertex_pool[$urandom_range(0, pool_size - 1)];
    endcase
  endfunction

  task automatic send_request(input vertex_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 24);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_func          <= r.func;
    in_vertex_a      <= r.va;
    in_vertex_b      <= r.vb;
    in_vertex_c      <= r.vc;
    in_element_value <= r.value;
    in_element_area  <= r.area;
    in_read_vertex   <= r.rvert;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_add(input logic [VTX_W-1:0] va, input logic [VTX_W-1:0] vb,
                          input logic [VTX_W-1:0] vc, input logic signed [VAL_W-1:0] value,
                          input logic [VAL_W-1:0] area);
    vertex_req_t r;
    r = random_request();
    r.func  = FUNC_ADD;
    r.va    = va;
    r.vb    = vb;
    r.vc    = vc;
    r.value = value;
    r.area  = area;
    send_request(r);
  endtask

  task automatic send_read(input logic [VTX_W-1:0] vnum);
    vertex_req_t r;
    r = random_request();
    r.func  = FUNC_READ;
    r.rvert = vnum;
    send_request(r);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_averages.size() != 0) @(posedge clk);
  endtask

  // Batches of adds onto a few vertices followed by reads of them, with some noise.
  task automatic run_random_traffic(input int count);
    int sent;
    int n_adds;
    int n_reads;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(random_request());
        sent++;
      end else begin
        pool_size = $urandom_range(1, 4);
        foreach (vertex_pool[j]) begin
          case ($urandom_range(0, 5))
            0:       vertex_pool[j] = 1;
            1:       vertex_pool[j] = VTX_W'(VTX_COUNT);
            2:       vertex_pool[j] = VTX_W'($urandom_range(1, 16));
            default: vertex_pool[j] = VTX_W'($urandom_range(1, VTX_COUNT));
          endcase
        end
        n_adds = $urandom_range(1, 8);
        repeat (n_adds) begin
          send_add(pick_corner(), pick_corner(), pick_corner(), random_value(), random_area());
          sent++;
          if ($urandom_range(0, 5) == 0) begin
            send_read(vertex_pool[$urandom_range(0, pool_size - 1)]);
            sent++;
          end
        end
        // Zero reads leaves the sums building up into later batches.
        n_reads = $urandom_range(0, pool_size);
        repeat (n_reads) begin
          send_read(vertex_pool[$urandom_range(0, pool_size - 1)]);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int k;
    logic [VTX_W-1:0] v;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reads of untouched and out-of-range vertices.
    send_read(1);
    send_read(0);
    send_read(2047);
    send_add(1, 2, 3, 32'sh0001_0000, 32'h0001_0000);
    send_add(1, 2, 1024, -32'sh0003_0000, 32'h0002_8000);
    send_read(1);
    send_read(2);
    // Out-of-range corners are skipped, the rest still update.
    send_add(0, 5, 2047, -32'sh0000_1234, 32'h0000_4000);
    send_add(1025, 5, 0, 32'sh0007_0000, 32'h0001_0000);
    // A corner named twice takes two contributions.
    send_add(7, 7, 8, 32'sh0000_8000, 32'h0000_0003);
    send_read(7);
    send_read(8);
    // Value sums driven past both ends of the 64-bit range.
    send_add(9, 9, 9, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_read(9);
    send_add(10, 10, 10, 32'sh8000_0000, 32'hFFFF_FFFF);
    send_read(10);
    // Zero area leaves the vertex without weight.
    send_add(11, 12, 1024, 32'sh0123_4567, 32'h0000_0000);
    send_read(11);
    send_read(1024);
    // Negative averages truncate toward zero.
    send_add(13, 13, 14, -32'sd3, 32'd1);
    send_add(13, 14, 14, -32'sd4, 32'd2);
    send_read(13);
    send_read(14);
    send_read(3);
    send_read(5);
    wait_for_drain();

    // Many maximum areas piled onto one vertex give a large area sum.
    v = VTX_W'($urandom_range(1, VTX_COUNT));
    for (k = 0; k < 40; k++)
      send_add(v, v, v, $urandom_range(0, 255), 32'hFFFF_FFFF);
    send_read(v);

    run_random_traffic(550);

    // Long receiver hold while requests keep coming, then a full drain.
    wait_for_drain();
    stall_orders <= stall_orders + 1;
    no_gaps = 1'b1;
    burst_left = 0;
    for (k = 0; k < 16; k++) begin
      if (k % 3 == 0)
        send_add(VTX_W'($urandom_range(100, 103)), VTX_W'($urandom_range(100, 103)),
                 VTX_W'($urandom_range(100, 103)), random_value(), random_area());
      else
        send_read(VTX_W'($urandom_range(100, 103)));
    end
    no_gaps = 1'b0;
    wait_for_drain();

    run_random_traffic(550);

    wait_for_drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    $display("Covered %0d triangle adds and %0d vertex reads, including a long receiver hold.",
             board.adds_seen, board.reads_seen);
    $display("Checked %0d averages: %0d saturated, %0d without weight.",
             board.results_checked, board.sat_results, board.empty_results);
    if (board.mismatches == 0 && board.pending_averages.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
